[rtl/erf_pkg.sv]
`timescale 1ns / 1ps

package erf_pkg;

   // Grid rows are always this many bits wide, whatever the store depth.
   localparam int ROW_BITS = 32;
   localparam int ROW_IDX_BITS = $clog2(ROW_BITS);

   // Width of the size register and of the row counter.
   localparam int SIZE_BITS = 6;
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 6'd25;

   // Default depth of the owned-tile store.
   localparam int GRID_MAX_DEFAULT = 32;

   // Entries in the job queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   typedef logic [ROW_BITS-1:0] row_type;
   typedef logic [SIZE_BITS-1:0] size_type;

   // One fill job, handed from the front to the back.
   typedef struct packed {
      size_type n;
   } cmd_type;

   // Status reported by the back to the front.
   typedef struct packed {
      logic load_done;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SEED,
      ST_SWEEP,
      ST_EMIT
   } back_state_type;

   // Clamp the requested size into the range 1 .. lim.
   function automatic size_type effective_size(size_type raw, size_type lim);
      size_type n;
      n = raw;
      if (n == size_type'(0)) begin
         n = size_type'(1);
      end
      if (n > lim) begin
         n = lim;
      end
      return n;
   endfunction

   // Ones in the columns that are in use.
   function automatic row_type width_mask(size_type n);
      row_type m;
      if (n >= size_type'(ROW_BITS)) begin
         m = '1;
      end else begin
         m = (row_type'(1) << n) - row_type'(1);
      end
      return m;
   endfunction

   // Ones in the first and the last used column.
   function automatic row_type edge_cols(size_type n);
      return row_type'(1) | (row_type'(1) << (n - size_type'(1)));
   endfunction

endpackage

[rtl/erf_ram.sv]
`timescale 1ns / 1ps

module erf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/erf_front.sv]
`timescale 1ns / 1ps

module erf_front import erf_pkg::*; #(
   parameter int GRID_MAX = GRID_MAX_DEFAULT,
   localparam int AW = $clog2(GRID_MAX)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  row_type         req_tdata,
   input  logic            req_tlast,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  size_type        csr_data,
   input  logic            q_full,
   output logic            q_push,
   output cmd_type         q_cmd,
   input  back_status_type status,
   output logic            ram_we,
   output logic [AW-1:0]   ram_waddr,
   output row_type         ram_wdata
);

   localparam int LIM = (GRID_MAX < ROW_BITS) ? GRID_MAX : ROW_BITS;
   localparam int CW = SIZE_BITS + 1;
   localparam size_type COUNT_MAX = '1;

   size_type row_count_ff, row_count_in;
   size_type size_ff, size_in;
   logic     hold_ff, hold_in;
   logic     accept;

   // New rows wait while the back still copies the previous grid.
   assign req_tready = !hold_ff && !q_full;
   assign accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // Rows at or beyond the store depth are dropped.
   assign ram_we = accept && ({1'b0, row_count_ff} < CW'(GRID_MAX));
   assign ram_waddr = row_count_ff[AW-1:0];
   assign ram_wdata = req_tdata;

   // Row counting, job hand-off and the size register.
   always_comb begin
      row_count_in = row_count_ff;
      hold_in = hold_ff;
      size_in = size_ff;
      q_push = 1'b0;
      q_cmd.n = effective_size(size_ff, size_type'(LIM));
      if (csr_valid) begin
         size_in = csr_data;
      end
      if (status.load_done) begin
         hold_in = 1'b0;
      end
      if (accept) begin
         if (req_tlast) begin
            q_push = 1'b1;
            hold_in = 1'b1;
            row_count_in = '0;
         end else if (row_count_ff != COUNT_MAX) begin
            row_count_in = row_count_ff + size_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         size_ff <= SIZE_RESET;
         hold_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         size_ff <= size_in;
         hold_ff <= hold_in;
      end
   end

endmodule

[rtl/erf_queue.sv]
`timescale 1ns / 1ps

module erf_queue import erf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type          mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Queue entries carry payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/erf_back.sv]
`timescale 1ns / 1ps

module erf_back import erf_pkg::*; #(
   parameter int GRID_MAX = GRID_MAX_DEFAULT,
   localparam int AW = $clog2(GRID_MAX)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   output logic            q_pop,
   input  cmd_type         q_cmd,
   output back_status_type status,
   output logic            ram_re,
   output logic [AW-1:0]   ram_raddr,
   input  row_type         ram_rdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output row_type         rsp_tdata,
   output logic            rsp_tlast
);

   back_state_type state_ff, state_in;
   size_type       n_ff, n_in;
   size_type       k_ff, k_in;
   row_type        free_ff [ROW_BITS];
   row_type        free_in [ROW_BITS];
   row_type        reached_ff [ROW_BITS];
   row_type        reached_in [ROW_BITS];
   logic           out_valid_ff, out_valid_in;
   row_type        out_data_ff, out_data_in;
   logic           out_last_ff, out_last_in;
   row_type        mask;
   row_type        edges;
   logic [ROW_IDX_BITS-1:0] k_prev;

   assign mask = width_mask(n_ff);
   assign edges = edge_cols(n_ff);
   assign k_prev = ROW_IDX_BITS'(k_ff - size_type'(1));
   assign ram_raddr = k_ff[AW-1:0];

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;

   // Sequencer: copy the free tiles, seed the border, sweep all rows in
   // parallel until nothing changes, then emit the complement row by row.
   always_comb begin
      row_type grow;
      row_type next_row;
      logic    changed;
      state_in = state_ff;
      n_in = n_ff;
      k_in = k_ff;
      free_in = free_ff;
      reached_in = reached_ff;
      q_pop = 1'b0;
      status.load_done = 1'b0;
      ram_re = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      changed = 1'b0;
      grow = '0;
      next_row = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               n_in = q_cmd.n;
               k_in = '0;
               for (int r = 0; r < ROW_BITS; r++) begin
                  free_in[r] = '0;
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ram_re = (k_ff < n_ff);
            if (k_ff != size_type'(0)) begin
               free_in[k_prev] = ~ram_rdata & mask;
            end
            if (k_ff == n_ff) begin
               status.load_done = 1'b1;
               state_in = ST_SEED;
            end else begin
               k_in = k_ff + size_type'(1);
            end
         end
         ST_SEED: begin
            for (int r = 0; r < ROW_BITS; r++) begin
               if (r == 0 || size_type'(r) == n_ff - size_type'(1)) begin
                  reached_in[r] = free_ff[r] & mask;
               end else begin
                  reached_in[r] = free_ff[r] & edges;
               end
            end
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            for (int r = 0; r < ROW_BITS; r++) begin
               grow = (reached_ff[r] << 1) | (reached_ff[r] >> 1);
               if (r > 0) begin
                  grow = grow | reached_ff[r - 1];
               end
               if (r < ROW_BITS - 1) begin
                  grow = grow | reached_ff[r + 1];
               end
               next_row = reached_ff[r] | (grow & free_ff[r]);
               if (next_row != reached_ff[r]) begin
                  changed = 1'b1;
               end
               reached_in[r] = next_row;
            end
            if (!changed) begin
               k_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in = ~reached_ff[0] & mask;
               out_last_in = (k_ff == n_ff - size_type'(1));
               for (int r = 0; r < ROW_BITS - 1; r++) begin
                  reached_in[r] = reached_ff[r + 1];
               end
               reached_in[ROW_BITS - 1] = '0;
               k_in = k_ff + size_type'(1);
               if (k_ff == n_ff - size_type'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working rows and the output register hold payload only.
   always_ff @(posedge clock) begin
      n_ff <= n_in;
      k_ff <= k_in;
      free_ff <= free_in;
      reached_ff <= reached_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

endmodule

[rtl/enclosed_region_fill_top.sv]
`timescale 1ns / 1ps

// Enclosed region fill. A square grid of up to 32 by 32 tiles is loaded one
// row per request (bit c set for an owned tile, tlast on the final row); the
// block then floods from the open border tiles in 4-neighbour steps and
// returns one response per used row, with bits set for owned tiles and for
// every tile the flood could not reach. Rows are taken while req_tready is
// high. When the final row is accepted the job passes through a short queue
// to the back, which takes it in the next cycle if it is idle and then copies
// the N used rows out of the row store. No request is taken from the final
// row until that copy ends, and the wait is longer while the back still
// finishes the previous grid. The back then seeds the border, sweeps all rows
// in parallel until a sweep changes nothing, and emits one response row at a
// time while rsp_tready is high. Rows of the next grid can be loaded while
// the sweeps and the responses of the last one are still running. The size
// register (csr_data, clamped to 1 .. 32 and to the store depth) is sampled
// when the final row of a grid is accepted.
module enclosed_region_fill_top import erf_pkg::*; #(
   parameter int GRID_MAX = GRID_MAX_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   // req_tdata: owned_row [31:0]; req_tlast: last_row
   input  logic     req_tvalid,
   output logic     req_tready,
   input  row_type  req_tdata,
   input  logic     req_tlast,
   // rsp_tdata: filled_row [31:0]; rsp_tlast: last_result
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output row_type  rsp_tdata,
   output logic     rsp_tlast,
   // csr_data: size_in_use [5:0]
   input  logic     csr_valid,
   output logic     csr_ready,
   input  size_type csr_data
);

   localparam int AW = $clog2(GRID_MAX);

   logic            q_push, q_pop, q_full, q_empty;
   cmd_type         push_cmd, pop_cmd;
   back_status_type status;
   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   row_type         ram_wdata, ram_rdata;

   erf_front #(.GRID_MAX(GRID_MAX)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd),
      .status     (status),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata)
   );

   erf_ram #(.WIDTH(ROW_BITS), .DEPTH(GRID_MAX)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   erf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   erf_back #(.GRID_MAX(GRID_MAX)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_cmd      (pop_cmd),
      .status     (status),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A job is queued only for an accepted final row.
   a_push_on_last: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_tvalid && req_tready && req_tlast))
      else $error("job queued without a final row request");

   // The queue is never written when full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("job queue overflow");

   // The back never takes a job from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("job queue underflow");

   // The store is never written while the back is copying it.
   a_no_write_during_copy: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> !ram_we)
      else $error("row store written during copy");

endmodule

[bench/tb_enclosed_region_fill_top.sv]
`timescale 1ns / 1ps

module tb_enclosed_region_fill_top;
   import erf_pkg::*;

   localparam int GRID_LIMIT = 32;
   localparam int COUNT_CAP = 63;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 50;
   localparam int ROWS_PER_PHASE = 6;
   localparam int PRESSURE_HOLD = 800;

   typedef enum int {
      STYLE_UNIFORM,
      STYLE_DENSE,
      STYLE_SPARSE,
      STYLE_RING
   } row_style_type;

   typedef struct packed {
      logic    last;
      row_type row;
   } fill_result_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_tvalid = 1'b0;
   logic     req_tready;
   row_type  req_tdata = '0;
   logic     req_tlast = 1'b0;
   logic     rsp_tvalid;
   logic     rsp_tready = 1'b0;
   row_type  rsp_tdata;
   logic     rsp_tlast;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   size_type csr_data = '0;

   // Shadow copy of the grid store, the row counter and the size register.
   row_type  owned_copy [GRID_LIMIT];
   bit       row_loaded [GRID_LIMIT];
   int       load_count = 0;
   size_type size_reg = SIZE_RESET;

   fill_result_type expected_rows [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   enclosed_region_fill_top #(
      .GRID_MAX(GRID_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run must not outlast this, whatever the block does.
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Grid size after clamping into 1 .. GRID_LIMIT.
   function automatic int active_size();
      int n;
      n = size_reg;
      if (n < 1) begin
         n = 1;
      end
      if (n > GRID_LIMIT) begin
         n = GRID_LIMIT;
      end
      return n;
   endfunction

   // Flood the open tiles from the border and queue one expected row per grid row.
   function automatic void grid_fill_expect();
      int n;
      row_type mask;
      row_type edges;
      row_type spread;
      row_type nxt;
      row_type open_tiles [GRID_LIMIT];
      row_type seen [GRID_LIMIT];
      bit grew;
      fill_result_type res;
      n = active_size();
      mask = (n == GRID_LIMIT) ? '1 : ((row_type'(1) << n) - row_type'(1));
      edges = row_type'(1) | (row_type'(1) << (n - 1));
      for (int r = 0; r < n; r++) begin
         open_tiles[r] = ~owned_copy[r] & mask;
         seen[r] = open_tiles[r] & (((r == 0) || (r == n - 1)) ? mask : edges);
      end
      // Keep spreading to side and vertical neighbors until nothing changes.
      grew = 1'b1;
      while (grew) begin
         grew = 1'b0;
         for (int r = 0; r < n; r++) begin
            spread = seen[r] | (seen[r] << 1) | (seen[r] >> 1);
            if (r > 0) begin
               spread |= seen[r - 1];
            end
            if (r < n - 1) begin
               spread |= seen[r + 1];
            end
            nxt = seen[r] | (spread & open_tiles[r]);
            if (nxt != seen[r]) begin
               seen[r] = nxt;
               grew = 1'b1;
            end
         end
      end
      for (int r = 0; r < n; r++) begin
         res.row = ~seen[r] & mask;
         res.last = (r == n - 1);
         expected_rows.push_back(res);
      end
   endfunction

   // Update the shadow state for one accepted request.
   function automatic void model_accept_row(row_type row, bit last);
      if (load_count < GRID_LIMIT) begin
         owned_copy[load_count] = row;
         row_loaded[load_count] = 1'b1;
      end
      if (load_count < COUNT_CAP) begin
         load_count++;
      end
      if (last) begin
         grid_fill_expect();
         load_count = 0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Offer one request, with random idle cycles ahead of it.
   task automatic send_row(input row_type row, input bit last);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= row;
      req_tlast <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      model_accept_row(row, last);
   endtask

   // Send a whole grid load; a ring style draws an owned rectangle outline.
   task automatic send_grid(input int rows, input row_style_type style);
      int n;
      int top;
      int bot;
      int left;
      int right;
      row_type span;
      row_type row;
      n = active_size();
      top = $urandom_range(n - 1, 0);
      bot = $urandom_range(n - 1, top);
      left = $urandom_range(n - 1, 0);
      right = $urandom_range(n - 1, left);
      span = row_type'(((64'd1 << (right - left + 1)) - 64'd1) << left);
      for (int r = 0; r < rows; r++) begin
         case (style)
            STYLE_DENSE: begin
               row = $urandom | $urandom;
            end
            STYLE_SPARSE: begin
               row = $urandom & $urandom;
            end
            STYLE_RING: begin
               row = $urandom & $urandom & $urandom;
               if ((r == top) || (r == bot)) begin
                  row |= span;
               end else if ((r > top) && (r < bot)) begin
                  row |= (row_type'(1) << left) | (row_type'(1) << right);
               end
            end
            default: begin
               row = $urandom;
            end
         endcase
         send_row(row, r == rows - 1);
      end
   endtask

   // Write the size register; only called while the block is idle.
   task automatic write_size(input size_type value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      size_reg = value;
      csr_valid <= 1'b0;
   endtask

   // Let every outstanding response drain, then let the block settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_rows.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly small sizes, now and then the largest and the out-of-range ones.
   function automatic size_type pick_size();
      int p;
      p = $urandom_range(99, 0);
      if (p < 70) begin
         return size_type'($urandom_range(8, 1));
      end else if (p < 82) begin
         return size_type'($urandom_range(24, 9));
      end else if (p < 87) begin
         return size_type'(GRID_LIMIT);
      end else if (p < 91) begin
         return size_type'(0);
      end
      return size_type'($urandom_range(63, 33));
   endfunction

   // Response side: check each response and drive tready with stalls and holds.
   always @(posedge clock) begin : rsp_sink
      fill_result_type want;
      if ((rsp_tvalid === 1'b1) && (rsp_tready === 1'b1)) begin
         if (expected_rows.size() == 0) begin
            report_mismatch($sformatf("unexpected response %h", rsp_tdata));
         end else begin
            want = expected_rows.pop_front();
            if (rsp_tdata !== want.row) begin
               report_mismatch($sformatf("filled row %h, expected %h", rsp_tdata, want.row));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch($sformatf("last flag %b, expected %b", rsp_tlast, want.last));
            end
         end
      end
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // The size left by reset, with an outlined region to enclose.
   task automatic test_reset_size();
      send_grid(25, STYLE_RING);
      wait_idle();
   endtask

   // A size of zero acts as one; all-clear and all-owned single rows.
   task automatic test_size_floor();
      write_size(size_type'(0));
      send_row('0, 1'b1);
      send_row('1, 1'b1);
      wait_idle();
      write_size(size_type'(1));
      send_row($urandom, 1'b1);
      wait_idle();
   endtask

   // A closed ring encloses the center; an open one does not. High bits are junk.
   task automatic test_enclosed_ring();
      write_size(size_type'(3));
      send_row(32'hFFFF_FFFF, 1'b0);
      send_row(32'h0000_0005, 1'b0);
      send_row(32'hA5A5_A5A7, 1'b1);
      send_row(32'h0000_0007, 1'b0);
      send_row(32'h8000_0004, 1'b0);
      send_row(32'h0000_0007, 1'b1);
      wait_idle();
   endtask

   // Final row arrives early; the rest of the grid comes from earlier loads.
   task automatic test_short_load();
      send_row(32'h0000_0000, 1'b1);
      wait_idle();
   endtask

   // Oversized register value clamps to the full 32 by 32 grid.
   task automatic test_size_ceiling();
      row_type row;
      write_size(size_type'(63));
      for (int r = 0; r < GRID_LIMIT; r++) begin
         row = (r % 3 == 0) ? row_type'('0) : (r % 3 == 1) ? row_type'('1) : row_type'($urandom);
         send_row(row, r == GRID_LIMIT - 1);
      end
      wait_idle();
   endtask

   // More rows than the store holds, and past the point where the count saturates.
   task automatic test_overlong_load();
      write_size(size_type'(2));
      for (int r = 0; r < 66; r++) begin
         send_row($urandom, r == 65);
      end
      wait_idle();
   endtask

   // Hold the response side off while grids keep coming, so the input backs up.
   task automatic test_pressure();
      write_size(size_type'(4));
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = PRESSURE_HOLD;
      repeat (3) begin
         send_grid(4, STYLE_RING);
      end
      wait_idle();
   endtask

   // Random grids, sizes and load lengths under one idling setting.
   task automatic test_random_phase(input int idle_pct, input int stall_pct);
      int sent;
      int n;
      int rows;
      int p;
      bit complete;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < ROWS_PER_PHASE) begin
         if ($urandom_range(99, 0) < 40) begin
            wait_idle();
            write_size(pick_size());
         end
         n = active_size();
         rows = n;
         p = $urandom_range(99, 0);
         if ((p >= 80) && (p < 90) && (n > 1)) begin
            // A short load may only lean on store rows written before.
            rows = $urandom_range(n - 1, 1);
            complete = 1'b1;
            for (int r = rows; r < n; r++) begin
               complete &= row_loaded[r];
            end
            if (!complete) begin
               rows = n;
            end
         end else if (p >= 90) begin
            rows = n + $urandom_range(6, 1);
         end
         send_grid(rows, row_style_type'($urandom_range(3, 0)));
         sent += rows;
      end
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 20;
      recv_stall_pct = 20;
      test_reset_size();
      test_size_floor();
      test_enclosed_ring();
      test_short_load();
      test_size_ceiling();
      test_overlong_load();
      test_pressure();
      test_random_phase(0, 0);
      test_random_phase(76, 0);
      test_random_phase(0, 76);
      test_random_phase(28, 28);
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
